@@ rtl/one_bit_framebuffer_unit_macros.svh @@
// Assertion macros for the one-bit frame store.
`ifndef ONE_BIT_FRAMEBUFFER_UNIT_MACROS_SVH
`define ONE_BIT_FRAMEBUFFER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every edge once reset is released.
`define OBFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define OBFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define OBFB_ASSERT(lbl, prop, msg)
`define OBFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/obfb_pkg.sv @@
// Types and constants for the one-bit frame store.
package obfb_pkg;

  localparam int unsigned WIDTH_REG_W  = 8;
  localparam int unsigned HEIGHT_REG_W = 7;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned COLOUR_W     = 16;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned IDX_W        = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned IN_TDATA_W   = 48;
  localparam int unsigned OUT_TDATA_W  = 8;
  // linear pixel number: height below 128 times width below 256
  localparam int unsigned PIX_W        = 15;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hff;
  localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_DRAW = 2'd0,
    KIND_READ = 2'd1,
    KIND_FILL = 2'd2
  } kind_e;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_INVERT = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_FILL = 4'b1000
  } state_e;

endpackage

@@ rtl/one_bit_framebuffer_unit.sv @@
// One-bit-per-pixel frame store with pixel draw, pixel read and whole-frame fill.
//
//  channel  | dir | signals                        | beat carries
//  ---------+-----+--------------------------------+------------------------------
//  s_axis   | in  | tvalid, tready, tdata, tuser   | one command (draw/read/fill)
//  m_axis   | out | tvalid, tready, tdata          | pixel value of a read
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i| width, height, invert writes
//
// Draw and read each go through accept, byte read and modify/write or answer: the
// store is one byte-wide synchronous RAM and a draw is a read-modify-write of one byte.
// A fill writes ceil(W*H/8) bytes, one byte per cycle.
// After reset the RAM is swept to zero, MAX_WIDTH*MAX_HEIGHT/8 bytes (1024 by default);
// no command beat is taken during the sweep, config writes are.
// A read result sits in an output register; further beats are taken while it waits,
// and a second read stalls in its last cycle until the register frees.
`include "one_bit_framebuffer_unit_macros.svh"

module one_bit_framebuffer_unit
  import obfb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command stream
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata: x_pos [15:0], y_pos [31:16], colour [47:32]
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: kind [1:0]
  input  logic [KIND_W-1:0]       s_axis_tuser_i,
  // result stream
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // tdata: pixel_value [0], zeros [7:1]
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // register writes
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 7) / 8;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned CNT_W       = $clog2(STORE_BYTES + 1);

  // ---------------------------------------------------------------- registers
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic                    invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_REG_W'(128);
      height_q <= HEIGHT_REG_W'(64);
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        REG_INVERT: invert_q <= cfg_data_i[0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // effective frame size, clipped to the store's geometry
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  assign w_eff = ({{(POS_W-WIDTH_REG_W){1'b0}}, width_q} > POS_W'(MAX_WIDTH))
               ? WIDTH_REG_W'(MAX_WIDTH) : width_q;
  assign h_eff = ({{(POS_W-HEIGHT_REG_W){1'b0}}, height_q} > POS_W'(MAX_HEIGHT))
               ? HEIGHT_REG_W'(MAX_HEIGHT) : height_q;

  // ---------------------------------------------------------------- command decode
  logic [POS_W-1:0]    in_x, in_y;
  logic [COLOUR_W-1:0] in_colour;
  logic                in_bounds;
  logic [PIX_W-1:0]    in_pix;

  assign in_x      = s_axis_tdata_i[POS_W-1:0];
  assign in_y      = s_axis_tdata_i[2*POS_W-1:POS_W];
  assign in_colour = s_axis_tdata_i[2*POS_W+COLOUR_W-1:2*POS_W];

  // negative coordinates fall out through the sign bit
  assign in_bounds = !in_x[POS_W-1] && !in_y[POS_W-1]
                  && (in_x < {{(POS_W-WIDTH_REG_W){1'b0}}, w_eff})
                  && (in_y < {{(POS_W-HEIGHT_REG_W){1'b0}}, h_eff});
  assign in_pix = PIX_W'(in_y[HEIGHT_REG_W-1:0]) * PIX_W'(w_eff)
                + PIX_W'(in_x[WIDTH_REG_W-1:0]);

  // ---------------------------------------------------------------- control state
  state_e            state_q, state_d;
  kind_e             kind_q, kind_d;
  logic              bounds_q, bounds_d;
  logic              on_q, on_d;
  logic [PIX_W-1:0]  pix_q, pix_d;
  logic [CNT_W-1:0]  fill_cnt_q, fill_cnt_d;
  logic [CNT_W-1:0]  fill_end_q, fill_end_d;
  logic [BYTE_W-1:0] fill_val_q, fill_val_d;
  logic              out_valid_q, out_valid_d;
  logic              out_bit_q, out_bit_d;

  // frame bytes for a fill: ceil(W*H/8), never beyond the store
  logic [PIX_W-1:0]  area;
  logic [PIX_W:0]    area_up;
  logic [CNT_W-1:0]  fill_bytes;

  assign area       = PIX_W'(h_eff) * PIX_W'(w_eff);
  assign area_up    = {1'b0, area} + (PIX_W+1)'(7);
  assign fill_bytes = CNT_W'(area_up >> 3);

  // ---------------------------------------------------------------- frame RAM
  logic [BYTE_W-1:0] mem_q [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [BYTE_W-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign raddr = ADDR_W'(pix_q >> 3);

  logic [BYTE_W-1:0] bit_mask;
  logic [BYTE_W-1:0] mod_byte;
  logic              out_free;

  assign bit_mask = BYTE_W'(1) << pix_q[2:0];
  assign mod_byte = on_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    bounds_d    = bounds_q;
    on_d        = on_q;
    pix_d       = pix_q;
    fill_cnt_d  = fill_cnt_q;
    fill_end_d  = fill_end_q;
    fill_val_d  = fill_val_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_bit_d   = out_bit_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    waddr       = raddr;
    wdata       = mod_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d   = kind_e'(s_axis_tuser_i);
          bounds_d = in_bounds;
          on_d     = (in_colour != '0);
          pix_d    = in_pix;
          state_d  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        case (kind_q) inside
          KIND_DRAW, KIND_READ: begin
            mem_re  = bounds_q;
            state_d = ST_MOD;
          end
          KIND_FILL: begin
            fill_cnt_d = '0;
            fill_end_d = fill_bytes;
            fill_val_d = on_q ? BYTE_ONES : BYTE_ZEROS;
            state_d    = (fill_bytes == '0) ? ST_IDLE : ST_FILL;
          end
          default: state_d = ST_IDLE;  // unused kind: no effect
        endcase
      end
      ST_MOD: begin
        if (kind_q == KIND_READ) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_bit_d   = bounds_q && (rdata_q[pix_q[2:0]] ^ invert_q);
            state_d     = ST_IDLE;
          end
        end else begin
          mem_we  = bounds_q;
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_we     = 1'b1;
        waddr      = ADDR_W'(fill_cnt_q);
        wdata      = fill_val_q;
        fill_cnt_d = fill_cnt_q + CNT_W'(1);
        if (fill_cnt_d == fill_end_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reset starts a zero fill over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      kind_q      <= KIND_DRAW;
      fill_cnt_q  <= '0;
      fill_end_q  <= CNT_W'(STORE_BYTES);
      fill_val_q  <= BYTE_ZEROS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      fill_cnt_q  <= fill_cnt_d;
      fill_end_q  <= fill_end_d;
      fill_val_q  <= fill_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bounds_q  <= bounds_d;
    on_q      <= on_d;
    pix_q     <= pix_d;
    out_bit_q <= out_bit_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-1){1'b0}}, out_bit_q};

  // ---------------------------------------------------------------- checks
  `OBFB_ASSERT(a_no_rw_same_cycle, !(mem_we && mem_re), "RAM read and write in one cycle")
  `OBFB_ASSERT(a_fill_in_range, (state_q == ST_FILL) |-> (fill_cnt_q < fill_end_q), "fill past end")
  `OBFB_ASSERT(a_result_from_read, $rose(m_axis_tvalid_o) |-> $past((state_q == ST_MOD) && (kind_q == KIND_READ)), "result beat without read")

endmodule
